// ===== rtl/core/lphash_pkg.sv =====
// ----------------------------------------------------------------------------
// lphash_pkg
// Shared types and codes for the linear probing hash table.
// ----------------------------------------------------------------------------
package lphash_pkg;

    localparam int CFG_W = 9;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_PROBE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

// ===== rtl/core/linear_probe_hash_table.sv =====
// operation: the home slot comes from a bit-serial remainder of the key by the slot count,
// then the probed slots are read one after another, then the output register is loaded.
// One request at a time: a new request is taken only after the last result has been loaded
// into the output register; the slot memory has a single read port (one slot read per cycle).
// reset: synchronous active low; a clearing pass marks every slot free, during which no
// request is taken; table_entries resets to 256.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key-value store in an open addressing table with linear probing, put and get
// requests, one result per request.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lphash_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_table_entries,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [KEY_BITS-1:0]   s_key,
    input  logic [VALUE_BITS-1:0] s_put_value,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_result_value,
    output logic                  m_success
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int BC_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int ENT_W = 1 + KEY_BITS + VALUE_BITS;

    // slot memory: {occupied, key, value}
    logic [ENT_W-1:0] mem [CAPACITY];
    logic [ENT_W-1:0] rd_data_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    state_t state_reg, state_next;
    logic [CFG_W-1:0]      table_entries_reg, table_entries_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic                  is_get_reg, is_get_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [KEY_BITS-1:0]   shift_reg, shift_next;
    logic [VALUE_BITS-1:0] put_value_reg, put_value_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [IDX_W-1:0]      rem_reg, rem_next;
    logic [BC_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      start_reg, start_next;
    logic                  first_reg, first_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic                  res_ok_reg, res_ok_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0] m_result_value_reg, m_result_value_next;
    logic                  m_success_reg, m_success_next;

    logic [IDX_W:0]        div_trial;
    logic [IDX_W:0]        div_n;
    logic [IDX_W-1:0]      rem_step;
    logic                  rd_occ;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  key_match;
    logic [CNT_W-1:0]      idx_plus;
    logic [IDX_W-1:0]      idx_inc;
    logic                  wrapped;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_success      = m_success_reg;

    // one restoring step of key mod n
    assign div_trial = {rem_reg, shift_reg[KEY_BITS-1]};
    assign div_n     = (IDX_W + 1)'(n_reg);
    assign rem_step  = (div_trial >= div_n) ? IDX_W'(div_trial - div_n) : IDX_W'(div_trial);

    assign rd_occ    = rd_data_reg[ENT_W-1];
    assign rd_key    = rd_data_reg[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign rd_val    = rd_data_reg[VALUE_BITS-1:0];
    assign key_match = (rd_key == key_reg);

    assign idx_plus = CNT_W'(CNT_W'(idx_reg) + CNT_W'(1));
    assign idx_inc  = (idx_plus == n_reg) ? '0 : IDX_W'(idx_plus);
    assign wrapped  = (idx_inc == start_reg);

    always_comb begin
        state_next          = state_reg;
        table_entries_next  = table_entries_reg;
        clr_addr_next       = clr_addr_reg;
        is_get_next         = is_get_reg;
        key_next            = key_reg;
        shift_next          = shift_reg;
        put_value_next      = put_value_reg;
        n_next              = n_reg;
        rem_next            = rem_reg;
        bit_cnt_next        = bit_cnt_reg;
        idx_next            = idx_reg;
        start_next          = start_reg;
        first_next          = first_reg;
        res_value_next      = res_value_reg;
        res_ok_next         = res_ok_reg;
        m_valid_next        = m_valid_reg;
        m_result_value_next = m_result_value_reg;
        m_success_next      = m_success_reg;
        mem_we              = 1'b0;
        mem_waddr           = idx_reg;
        mem_wdata           = {1'b1, key_reg, put_value_reg};
        mem_re              = 1'b0;
        mem_raddr           = idx_inc;

        if (cfg_valid) begin
            table_entries_next = cfg_table_entries;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = IDX_W'(clr_addr_reg + IDX_W'(1));
                if (clr_addr_reg == IDX_W'(CAPACITY - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    is_get_next    = (s_opcode == OP_GET);
                    key_next       = s_key;
                    shift_next     = s_key;
                    put_value_next = s_put_value;
                    rem_next       = '0;
                    bit_cnt_next   = BC_W'(KEY_BITS - 1);
                    if (table_entries_reg == '0) begin
                        n_next = CNT_W'(1);
                    end else if (32'(table_entries_reg) > CAPACITY) begin
                        n_next = CNT_W'(CAPACITY);
                    end else begin
                        n_next = CNT_W'(table_entries_reg);
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next     = rem_step;
                shift_next   = shift_reg << 1;
                bit_cnt_next = BC_W'(bit_cnt_reg - BC_W'(1));
                if (bit_cnt_reg == '0) begin
                    // home slot known, fetch it
                    mem_re     = 1'b1;
                    mem_raddr  = rem_step;
                    idx_next   = rem_step;
                    start_next = rem_step;
                    first_next = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                first_next = 1'b0;
                if (!is_get_reg) begin
                    if (!rd_occ || key_match) begin
                        mem_we         = 1'b1;
                        res_value_next = put_value_reg;
                        res_ok_next    = 1'b1;
                        state_next     = ST_DONE;
                    end else if (wrapped) begin
                        // table full, put dropped
                        res_value_next = '0;
                        res_ok_next    = 1'b0;
                        state_next     = ST_DONE;
                    end else begin
                        mem_re   = 1'b1;
                        idx_next = idx_inc;
                    end
                end else begin
                    if (rd_occ && key_match) begin
                        res_value_next = rd_val;
                        res_ok_next    = 1'b1;
                        state_next     = ST_DONE;
                    end else if ((!rd_occ && !first_reg) || wrapped) begin
                        // an empty home slot does not stop the search
                        res_value_next = '0;
                        res_ok_next    = 1'b0;
                        state_next     = ST_DONE;
                    end else begin
                        mem_re   = 1'b1;
                        idx_next = idx_inc;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_result_value_next = res_value_reg;
                    m_success_next      = res_ok_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            table_entries_reg <= CFG_W'(256);
            clr_addr_reg      <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            table_entries_reg <= table_entries_next;
            clr_addr_reg      <= clr_addr_next;
            m_valid_reg       <= m_valid_next;
        end
        is_get_reg         <= is_get_next;
        key_reg            <= key_next;
        shift_reg          <= shift_next;
        put_value_reg      <= put_value_next;
        n_reg              <= n_next;
        rem_reg            <= rem_next;
        bit_cnt_reg        <= bit_cnt_next;
        idx_reg            <= idx_next;
        start_reg          <= start_next;
        first_reg          <= first_next;
        res_value_reg      <= res_value_next;
        res_ok_reg         <= res_ok_next;
        m_result_value_reg <= m_result_value_next;
        m_success_reg      <= m_success_next;
    end

endmodule

// ===== sim/tb_linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Drives put and get requests into the hash table through a queue-fed driver,
// predicts every reply with its own copy of the slot table, and checks each
// result in order. Covers several slot counts, full tables, probe wrap, long
// collision chains and back pressure on both channels.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
    import lphash_pkg::*;

    localparam int SLOTS       = 256;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_PRINTS  = 50;

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } request_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             success;
    } reply_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_table_entries = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_opcode = OP_PUT;
    logic [KEY_W-1:0] s_key = '0;
    logic [VAL_W-1:0] s_put_value = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [VAL_W-1:0] m_result_value;
    logic             m_success;

    // model of the slot table
    logic             slot_used [SLOTS];
    logic [KEY_W-1:0] slot_keys [SLOTS];
    logic [VAL_W-1:0] slot_vals [SLOTS];
    logic [CFG_W-1:0] entries_cfg = 9'd256;

    request_t         requests_waiting [$];
    reply_t           replies_due [$];
    logic [KEY_W-1:0] known_keys [$];

    int error_count = 0;
    int sent_count = 0;
    int got_count = 0;
    int put_count = 0;
    int get_count = 0;
    int hit_count = 0;
    int miss_count = 0;
    int cfg_writes = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    logic long_hold_done = 1'b0;

    linear_probe_hash_table #(
        .CAPACITY   (SLOTS),
        .KEY_BITS   (KEY_W),
        .VALUE_BITS (VAL_W)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_table_entries (cfg_table_entries),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_key             (s_key),
        .s_put_value       (s_put_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_value    (m_result_value),
        .m_success         (m_success)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned slot_span(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > SLOTS)
            return SLOTS;
        return v;
    endfunction

    // linear probe over the model table, updating it on a put
    function automatic reply_t probe_table(input request_t r);
        reply_t      rep;
        int unsigned n;
        int unsigned home;
        int unsigned idx;
        int unsigned steps;
        logic        done;
        n = slot_span(entries_cfg);
        home = r.key % n;
        idx = home;
        steps = 0;
        done = 1'b0;
        rep.value = '0;
        rep.success = 1'b0;
        if (r.op == OP_PUT) begin
            while (!done && steps < n) begin
                if (!slot_used[idx] || slot_keys[idx] == r.key) begin
                    slot_used[idx] = 1'b1;
                    slot_keys[idx] = r.key;
                    slot_vals[idx] = r.value;
                    rep.value = r.value;
                    rep.success = 1'b1;
                    done = 1'b1;
                end else begin
                    idx = (idx + 1) % n;
                    steps++;
                end
            end
        end else begin
            while (!done) begin
                if (slot_used[idx] && slot_keys[idx] == r.key) begin
                    rep.value = slot_vals[idx];
                    rep.success = 1'b1;
                    done = 1'b1;
                end else begin
                    idx = (idx + 1) % n;
                    // a get stops on a free slot or when it wraps home
                    if (idx == home || !slot_used[idx])
                        done = 1'b1;
                end
            end
        end
        return rep;
    endfunction

    function automatic request_t random_request(input int unsigned put_pct);
        request_t    r;
        int unsigned pick;
        int unsigned n;
        n = slot_span(entries_cfg);
        pick = $urandom_range(0, 99);
        r.op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
        if (pick < 40 && known_keys.size() > 0) begin
            r.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        end else if (pick < 60 && known_keys.size() > 0) begin
            // same home slot as a stored key, so chains grow
            r.key = known_keys[$urandom_range(0, known_keys.size() - 1)]
                    + n * $urandom_range(1, 4);
        end else if (pick < 70) begin
            case ($urandom_range(0, 2))
                0: r.key = '0;
                1: r.key = '1;
                default: r.key = 32'd1 << $urandom_range(0, KEY_W - 1);
            endcase
        end else begin
            r.key = $urandom;
        end
        pick = $urandom_range(0, 9);
        r.value = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
        if (r.op == OP_PUT) begin
            known_keys.push_back(r.key);
            if (known_keys.size() > 48)
                void'(known_keys.pop_front());
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < MAX_PRINTS)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        request_t r;
        r.op = op;
        r.key = key;
        r.value = value;
        requests_waiting.push_back(r);
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic drain_all();
        @(negedge aclk);
        while (requests_waiting.size() != 0 || s_valid || replies_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_entries(input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_table_entries <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        entries_cfg = v;
        cfg_writes++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] entries, input int count,
                             input int unsigned put_pct);
        drain_all();
        write_entries(entries);
        @(negedge aclk);
        repeat (count)
            requests_waiting.push_back(random_request(put_pct));
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                request_t r;
                r.op = s_opcode;
                r.key = s_key;
                r.value = s_put_value;
                replies_due.push_back(probe_table(r));
                sent_count++;
                if (s_opcode == OP_PUT)
                    put_count++;
                else
                    get_count++;
            end
            if (!s_valid || s_ready) begin
                if (requests_waiting.size() != 0 &&
                    ((sent_count >= 300 && sent_count < 500) ||
                     $urandom_range(0, 99) >= 17)) begin
                    request_t nxt;
                    nxt = requests_waiting.pop_front();
                    s_valid <= 1'b1;
                    s_opcode <= nxt.op;
                    s_key <= nxt.key;
                    s_put_value <= nxt.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                reply_t want;
                got_count++;
                if (m_success)
                    hit_count++;
                else
                    miss_count++;
                if (replies_due.size() == 0) begin
                    flag_error($sformatf("unexpected result value %h success %b",
                                         m_result_value, m_success));
                end else begin
                    want = replies_due.pop_front();
                    if (m_result_value !== want.value)
                        flag_error($sformatf("result %0d: result_value %h, want %h",
                                             got_count, m_result_value, want.value));
                    if (m_success !== want.success)
                        flag_error($sformatf("result %0d: success %b, want %b",
                                             got_count, m_success, want.success));
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (!long_hold_done && got_count == 100) begin
                // long hold-off so the block backs up into its input
                hold_left <= LONG_HOLD;
                long_hold_done <= 1'b1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (got_count >= 300 && got_count < 500) ||
                           ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready) ||
                     (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_keys[i] = '0;
            slot_vals[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset slot count
        @(negedge aclk);
        push_request(OP_GET, 32'h0, 32'hFFFF_FFFF);
        push_request(OP_PUT, 32'h0, 32'h0);
        push_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(OP_GET, 32'h0, 32'h1234_5678);
        push_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
        push_request(OP_PUT, 32'h100, 32'hA5A5_A5A5);
        push_request(OP_GET, 32'h100, 32'h0);
        push_request(OP_PUT, 32'h0, 32'h5A5A_5A5A);
        push_request(OP_GET, 32'h0, 32'h0);
        push_request(OP_GET, 32'h200, 32'h0);
        // home slot 255 is taken, so this wraps past slots 0 and 1
        push_request(OP_PUT, 32'h1FF, 32'h8000_0001);
        push_request(OP_GET, 32'h1FF, 32'h0);

        // single slot, already holding key 0: other keys find it full
        drain_all();
        write_entries(9'd0);
        @(negedge aclk);
        push_request(OP_PUT, 32'h5, 32'h1111_1111);
        push_request(OP_GET, 32'h0, 32'h0);
        push_request(OP_PUT, 32'h0, 32'h2222_2222);
        push_request(OP_GET, 32'h7, 32'h0);
        push_request(OP_GET, 32'h5, 32'h0);

        // out of range count, old entries above slot 0 visible again
        drain_all();
        write_entries(9'd511);
        @(negedge aclk);
        push_request(OP_GET, 32'h100, 32'h0);
        push_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
        push_request(OP_GET, 32'h0, 32'h0);

        drain_all();
        write_entries(9'd1);
        @(negedge aclk);
        push_request(OP_PUT, 32'h8000_0000, 32'h3333_3333);
        push_request(OP_GET, 32'h0, 32'h0);

        // random part
        run_phase(9'd256, 200, 60);
        run_phase(9'd7, 100, 50);
        run_phase(9'd100, 150, 55);
        run_phase(9'd0, 50, 50);
        run_phase(9'd37, 150, 50);
        run_phase(9'd511, 150, 60);
        run_phase(9'd2, 50, 50);
        run_phase(9'd256, 200, 75);

        drain_all();
        repeat (KEY_W + SLOTS + 4) @(posedge aclk);
        if (replies_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", replies_due.size()));

        $display("covered %0d puts and %0d gets across %0d slot count writes",
                 put_count, get_count, cfg_writes);
        $display("%0d requests hit or stored, %0d missed or hit a full table",
                 hit_count, miss_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
